>>> hw/rtl/irs_pkg.sv
package irs_pkg;

	localparam int DEF_MAX_WIDTH = 2048;
	localparam int MAX_OFFSET    = 64;

	localparam int PIX_W  = 8;
	localparam int COL_W  = 11;
	localparam int CFG_W  = 12;
	localparam int OFF_W  = 8;
	localparam int IDX_W  = 1;

	// output tdata: pixel_out, out_column, zero fill to whole bytes
	localparam int OUT_DATA_W = ((PIX_W + COL_W + 7) / 8) * 8;

	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [IDX_W-1:0] REG_SHIFT_OFFSET = 1'd1;

	localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 12'd640;
	localparam logic [OFF_W-1:0] RST_SHIFT_OFFSET = 8'd0;

endpackage

>>> hw/rtl/irs_line_store.sv
module irs_line_store #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [irs_pkg::PIX_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [irs_pkg::PIX_W-1:0] rd_data
);
	import irs_pkg::*;

	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> hw/rtl/interlaced_row_shift_unit.sv
// An input item is accepted only in ST_IDLE; its first result, if any, goes via ST_CHECK
// (line-store read issued) and ST_LOAD (output registers loaded) to m_tdata; an output
// stall holds the block in ST_CHECK. Each item is finished before the next is accepted;
// each result needs one line-store read (one port, registered read) plus an output load.
// Reset (arst_n low): row and column counters and emit pointer clear, registers return to
// width 640 and offset 0. Line-store contents are not cleared.
module interlaced_row_shift_unit #(
	parameter int MAX_WIDTH = irs_pkg::DEF_MAX_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_we,
	input  logic [irs_pkg::IDX_W-1:0]      cfg_index,
	input  logic [irs_pkg::CFG_W-1:0]      cfg_data,
	// input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [irs_pkg::PIX_W-1:0]      s_tdata,   // [7:0] pixel_in
	input  logic                           s_tuser,   // frame_start
	// output stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [irs_pkg::OUT_DATA_W-1:0] m_tdata,   // [7:0] pixel_out, [18:8] out_column
	output logic                           m_tlast    // burst_last
);
	import irs_pkg::*;

	localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW   = CW + 1;
	localparam int CMPW = (WW > CFG_W) ? WW : CFG_W;
	localparam int SW   = ((WW > OFF_W) ? WW : OFF_W) + 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LOAD
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0]        image_width_q;
	logic signed [OFF_W-1:0] shift_offset_q;

	logic [CW-1:0]           col_q;
	logic                    odd_q;
	logic [WW-1:0]           next_q;
	logic [WW-1:0]           width_q;
	logic signed [OFF_W-1:0] shift_q;
	logic [CW-1:0]           cur_col_q;
	logic                    last_q;

	logic [COL_W-1:0]        col_s1;
	logic                    blast_s1;

	logic [PIX_W-1:0]        pix_out_q;
	logic [COL_W-1:0]        col_out_q;
	logic                    tlast_q;
	logic                    tvalid_q;

	// next column selection, clamped line-store address
	function automatic logic col_ready(input logic [WW-1:0] e, input logic [WW-1:0] w,
			input logic signed [OFF_W-1:0] sh, input logic [CW-1:0] c, input logic lst);
		logic signed [SW-1:0] src;
		logic signed [SW-1:0] cs;
		src = $signed({{(SW-WW){1'b0}}, e}) + SW'(sh);
		cs  = $signed({{(SW-CW){1'b0}}, c});
		return (e < w) && (lst || (src <= cs));
	endfunction

	logic                    accept;
	logic                    fs_col0;
	logic [CW-1:0]           col_eff;
	logic                    odd_eff;
	logic                    new_row;
	logic [CMPW-1:0]         iw_ext;
	logic [WW-1:0]           width_lat;
	logic signed [OFF_W-1:0] off_sat;
	logic signed [OFF_W-1:0] odd_shift;
	logic signed [OFF_W-1:0] even_shift;
	logic [WW-1:0]           width_use;
	logic                    last_in;

	logic [WW-1:0]           next_p1;
	logic                    emit_now;
	logic                    emit_more;
	logic                    out_free;
	logic signed [SW-1:0]    src_now;
	logic [CW-1:0]           rd_addr;
	logic                    rd_en;
	logic [PIX_W-1:0]        rd_data;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		fs_col0 = s_tuser;
		col_eff = fs_col0 ? '0 : col_q;
		odd_eff = fs_col0 ? 1'b0 : odd_q;
		new_row = (col_eff == '0);

		iw_ext = CMPW'(image_width_q);
		if (iw_ext == '0) begin
			width_lat = WW'(1);
		end else if (iw_ext > CMPW'(MAX_WIDTH)) begin
			width_lat = WW'(MAX_WIDTH);
		end else begin
			width_lat = WW'(iw_ext);
		end

		if (shift_offset_q > OFF_W'(MAX_OFFSET)) begin
			off_sat = OFF_W'(MAX_OFFSET);
		end else if (shift_offset_q < -OFF_W'(MAX_OFFSET)) begin
			off_sat = -OFF_W'(MAX_OFFSET);
		end else begin
			off_sat = shift_offset_q;
		end
		// halve, truncating toward zero
		odd_shift  = $signed(off_sat + OFF_W'(off_sat[OFF_W-1])) >>> 1;
		even_shift = odd_shift - off_sat;

		width_use = new_row ? width_lat : width_q;
		last_in   = ({1'b0, col_eff} + 1'b1) >= width_use;
	end

	always_comb begin
		next_p1   = next_q + 1'b1;
		emit_now  = col_ready(next_q, width_q, shift_q, cur_col_q, last_q);
		emit_more = col_ready(next_p1, width_q, shift_q, cur_col_q, last_q);
		out_free  = !tvalid_q || m_tready;
		rd_en     = (state_q == ST_CHECK) && emit_now && out_free;

		src_now = $signed({{(SW-WW){1'b0}}, next_q}) + SW'(shift_q);
		if (src_now < 0) begin
			rd_addr = '0;
		end else if (src_now > $signed(SW'(width_q) - SW'(1))) begin
			rd_addr = CW'(width_q - 1'b1);
		end else begin
			rd_addr = CW'(src_now);
		end
	end

	irs_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_store (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (col_eff),
		.wr_data (s_tdata),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			image_width_q  <= RST_IMAGE_WIDTH;
			shift_offset_q <= RST_SHIFT_OFFSET;
			col_q          <= '0;
			odd_q          <= 1'b0;
			next_q         <= '0;
			width_q        <= WW'(1);
			shift_q        <= '0;
			cur_col_q      <= '0;
			last_q         <= 1'b0;
			col_s1         <= '0;
			blast_s1       <= 1'b0;
			pix_out_q      <= '0;
			col_out_q      <= '0;
			tlast_q        <= 1'b0;
			tvalid_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
					REG_SHIFT_OFFSET: shift_offset_q <= cfg_data[OFF_W-1:0];
					default: ;
				endcase
			end

			if (tvalid_q && m_tready) begin
				tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (new_row) begin
							width_q <= width_lat;
							shift_q <= odd_eff ? odd_shift : even_shift;
							next_q  <= '0;
						end
						cur_col_q <= col_eff;
						last_q    <= last_in;
						col_q     <= last_in ? '0 : col_eff + 1'b1;
						odd_q     <= last_in ? !odd_eff : odd_eff;
						state_q   <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (!emit_now) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						col_s1   <= COL_W'(next_q);
						blast_s1 <= !emit_more;
						next_q   <= next_p1;
						state_q  <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					pix_out_q <= rd_data;
					col_out_q <= col_s1;
					tlast_q   <= blast_s1;
					tvalid_q  <= 1'b1;
					state_q   <= ST_CHECK;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tlast  = tlast_q;
	assign m_tdata  = OUT_DATA_W'({col_out_q, pix_out_q});

endmodule

>>> hw/rtl/irs_checker.sv
module irs_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [irs_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                           m_tlast
);
	import irs_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output transaction changed while stalled");

	// one item at a time: input closes right after a transaction
	a_in_single: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted twice in a row");

	// burst still open: no new input
	a_burst_open: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> !s_tready)
		else $error("input opened inside a result burst");

	// a fresh result only appears while the block is busy with an item
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !s_tready)
		else $error("result appeared while idle");

endmodule

bind interlaced_row_shift_unit irs_checker u_irs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

>>> bench/row_shift_checker.sv
module row_shift_checker
	import irs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [IDX_W-1:0]      cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [PIX_W-1:0]      s_tdata,   // [7:0] pixel_in
	input  logic                  s_tuser,   // frame_start
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] pixel_out, [18:8] out_column
	input  logic                  m_tlast,   // burst_last
	output int                    fail_cnt,
	output int                    pending
);

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic [COL_W-1:0] col;
		logic             last;
	} shifted_px_t;

	shifted_px_t             shifted_q[$];
	logic [PIX_W-1:0]        line_buf [DEF_MAX_WIDTH];
	int                      col_cnt;
	int                      emit_col;
	int                      row_w;
	int                      row_shift;
	logic                    odd_row;
	logic [CFG_W-1:0]        width_reg;
	logic signed [OFF_W-1:0] offset_reg;
	int                      n_err = 0;

	// expected output columns caused by one accepted pixel
	task automatic shift_row_pixel(input logic [PIX_W-1:0] pix, input logic fs);
		int          w;
		int          off;
		int          half;
		int          src;
		int          n;
		logic        row_end;
		shifted_px_t ent;

		if (fs) begin
			col_cnt  = 0;
			odd_row  = 1'b0;
			emit_col = 0;
		end
		// width and shift are latched at the first column of each row
		if (col_cnt == 0) begin
			w = width_reg;
			if (w < 1)
				w = 1;
			if (w > DEF_MAX_WIDTH)
				w = DEF_MAX_WIDTH;
			off = offset_reg;
			if (off > MAX_OFFSET)
				off = MAX_OFFSET;
			if (off < -MAX_OFFSET)
				off = -MAX_OFFSET;
			half      = off / 2;
			row_w     = w;
			row_shift = odd_row ? half : half - off;
			emit_col  = 0;
		end
		line_buf[col_cnt] = pix;
		row_end = (col_cnt + 1 >= row_w);
		n = 0;
		while (emit_col < row_w) begin
			src = emit_col + row_shift;
			if (!row_end && src > col_cnt)
				break;
			if (src < 0)
				src = 0;
			if (src > row_w - 1)
				src = row_w - 1;
			ent.pix  = line_buf[src];
			ent.col  = emit_col[COL_W-1:0];
			ent.last = 1'b0;
			shifted_q.push_back(ent);
			n++;
			emit_col++;
		end
		if (n > 0) begin
			ent = shifted_q.pop_back();
			ent.last = 1'b1;
			shifted_q.push_back(ent);
		end
		if (row_end) begin
			col_cnt  = 0;
			odd_row  = ~odd_row;
			emit_col = 0;
		end else begin
			col_cnt = col_cnt + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		shifted_px_t ent;

		if (!arst_n) begin
			shifted_q.delete();
			col_cnt    = 0;
			emit_col   = 0;
			row_w      = 1;
			row_shift  = 0;
			odd_row    = 1'b0;
			width_reg  = RST_IMAGE_WIDTH;
			offset_reg = RST_SHIFT_OFFSET;
			pending   <= 0;
			fail_cnt  <= n_err;
		end else begin
			if (m_tvalid && m_tready) begin
				if (shifted_q.size() == 0) begin
					$display("%0t: unexpected transaction, expected none, actual pix %02h col %0d last %0b",
						$time, m_tdata[PIX_W-1:0], m_tdata[PIX_W +: COL_W], m_tlast);
					n_err++;
				end else begin
					ent = shifted_q.pop_front();
					if (m_tdata[PIX_W-1:0] !== ent.pix) begin
						$display("%0t: pixel_out col %0d expected %02h actual %02h",
							$time, ent.col, ent.pix, m_tdata[PIX_W-1:0]);
						n_err++;
					end
					if (m_tdata[PIX_W +: COL_W] !== ent.col) begin
						$display("%0t: out_column expected %0d actual %0d",
							$time, ent.col, m_tdata[PIX_W +: COL_W]);
						n_err++;
					end
					if (m_tlast !== ent.last) begin
						$display("%0t: burst_last col %0d expected %0b actual %0b",
							$time, ent.col, ent.last, m_tlast);
						n_err++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_WIDTH:  width_reg  = cfg_data;
					REG_SHIFT_OFFSET: offset_reg = cfg_data[OFF_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				shift_row_pixel(s_tdata, s_tuser);
			pending  <= shifted_q.size();
			fail_cnt <= n_err;
		end
	end

endmodule

>>> bench/tb_top.sv
module tb_top;
	import irs_pkg::*;

	localparam int N_ITEMS     = 270;
	localparam int IDLE_LIMIT  = 2000;
	localparam int DRAIN_CYC   = 8;
	localparam int MAX_IDLE    = 12;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [IDX_W-1:0]      cfg_index;
	logic [CFG_W-1:0]      cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [PIX_W-1:0]      s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;

	int n_fail;
	int n_pending;
	int n_sent   = 0;
	int n_recv   = 0;
	int eff_w    = 640;
	int idle_cyc = 0;
	bit tx_quiet = 0;
	bit rx_quiet = 0;

	interlaced_row_shift_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	row_shift_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.fail_cnt  (n_fail),
		.pending   (n_pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cyc <= 0;
		else
			idle_cyc <= idle_cyc + 1;
		if (idle_cyc >= IDLE_LIMIT) begin
			$display("interlaced_row_shift_unit test failed");
			$finish;
		end
	end

	task automatic tx_pixel(input logic [PIX_W-1:0] pix, input logic fs);
		int gap;

		gap = tx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pix;
		s_tuser  <= fs;
		do @(posedge clk); while (!s_tready);
		n_sent++;
		if (n_sent % 16 == 0)
			tx_quiet = ($urandom_range(0, 3) == 0);
	endtask

	task automatic send_row(input int len, input logic fs);
		for (int i = 0; i < len && n_sent < N_ITEMS; i++)
			tx_pixel(PIX_W'($urandom_range(0, 255)), fs && i == 0);
	endtask

	// hold the input until every pending transaction has come out
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (n_pending != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_IMAGE_WIDTH)
			eff_w = (val == 0) ? 1 : ((val > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(val));
	endtask

	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			int stall;
			stall = rx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			n_recv++;
			if (n_recv % 16 == 0)
				rx_quiet = ($urandom_range(0, 3) == 0);
		end
	end

	initial begin
		int w;
		int off;
		int pick;
		int rows;

		arst_n    = 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero width acts as one-pixel rows; offset beyond range saturates
		write_reg(REG_IMAGE_WIDTH, 12'd0);
		write_reg(REG_SHIFT_OFFSET, CFG_W'(127));
		tx_pixel(8'h00, 1'b1);
		tx_pixel(8'hFF, 1'b0);
		tx_pixel(8'hA5, 1'b0);

		// large negative offset: every column clamps to a row edge
		write_reg(REG_IMAGE_WIDTH, 12'd4);
		write_reg(REG_SHIFT_OFFSET, CFG_W'(-128));
		send_row(4, 1'b1);
		send_row(4, 1'b0);

		// registers rewritten mid-row take effect on the next row only
		write_reg(REG_IMAGE_WIDTH, 12'd5);
		write_reg(REG_SHIFT_OFFSET, CFG_W'(3));
		send_row(2, 1'b1);
		write_reg(REG_SHIFT_OFFSET, CFG_W'(-5));
		write_reg(REG_IMAGE_WIDTH, 12'd3);
		send_row(3, 1'b0);
		// frame restart drops the partial row
		send_row(2, 1'b1);
		send_row(3, 1'b1);

		// oversize width saturates; only a partial row, then restart
		write_reg(REG_IMAGE_WIDTH, 12'hFFF);
		write_reg(REG_SHIFT_OFFSET, CFG_W'(MAX_OFFSET));
		send_row(6, 1'b1);
		settle();

		while (n_sent < N_ITEMS) begin
			pick = $urandom_range(0, 15);
			case (pick)
				0:       w = 0;
				1:       w = 1;
				2:       w = DEF_MAX_WIDTH;
				3:       w = 4095;
				4, 5:    w = $urandom_range(25, 80);
				default: w = $urandom_range(2, 24);
			endcase
			pick = $urandom_range(0, 9);
			if (pick == 0)
				off = 0 - int'($urandom_range(MAX_OFFSET + 1, 128));
			else if (pick == 1)
				off = $urandom_range(MAX_OFFSET + 1, 127);
			else if (pick == 2)
				off = $urandom_range(0, 1) ? MAX_OFFSET : -MAX_OFFSET;
			else
				off = int'($urandom_range(0, 2 * MAX_OFFSET)) - MAX_OFFSET;
			if ($urandom_range(0, 1)) begin
				write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
				write_reg(REG_SHIFT_OFFSET, CFG_W'(off));
			end else begin
				write_reg(REG_SHIFT_OFFSET, CFG_W'(off));
				write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
			end

			if (eff_w >= 1024) begin
				send_row($urandom_range(8, 30), 1'b1);
			end else begin
				rows = (eff_w > 24) ? $urandom_range(1, 2) : $urandom_range(2, 5);
				for (int r = 0; r < rows; r++) begin
					// now and then a short row restarted by a new frame
					if ($urandom_range(0, 7) == 0)
						send_row($urandom_range(1, eff_w), 1'b1);
					else
						send_row(eff_w, r == 0);
					if ($urandom_range(0, 9) == 0)
						settle();
				end
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (n_pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (n_fail == 0 && n_pending == 0)
			$display("interlaced_row_shift_unit test passed");
		else
			$display("interlaced_row_shift_unit test failed");
		$finish;
	end

endmodule
